// File: rtl/rcgd_pkg.sv
// ----------------------------------------------------------------------------
// rcgd_pkg
// Shared types and constants for the grid ray cast distance unit: field
// widths, request and register codes, reset values, outcome codes and root unit sizes.
// ----------------------------------------------------------------------------
package rcgd_pkg;

	// field widths
	localparam int CELL_W    = 8;   // cell coordinate
	localparam int OFS_W     = 9;   // signed ray offset
	localparam int MAG_W     = 9;   // offset magnitude, up to 256
	localparam int COORD_W   = 10;  // signed walk coordinate, -512..511
	localparam int DIST_W    = 17;  // distance in mm
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;

	// distance arithmetic widths
	localparam int D2_W   = 18;     // squared cell distance, up to 130050
	localparam int CSQ_W  = 16;     // cell size squared
	localparam int RAD_W  = D2_W + CSQ_W;
	localparam int ROOT_W = RAD_W / 2;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_RAY   = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd1;

	// register reset values
	localparam logic [CELL_W-1:0] CELL_SIZE_RST = 8'd50;
	localparam logic [DIST_W-1:0] MAX_RANGE_RST = 17'd20000;

	typedef enum logic [1:0] {
		OUTCOME_HIT  = 2'd0,
		OUTCOME_LEFT = 2'd1,
		OUTCOME_NONE = 2'd2
	} outcome_t;

endpackage

// File: rtl/ray_cast_grid_distance_unit.sv
// ----------------------------------------------------------------------------
// ray_cast_grid_distance_unit
// Flow: a map write is done on its transfer. A ray walks one visited cell per cycle;
//   a hit then passes the multiply states X, Y, C and S, the root start state, the
//   bit-serial square root and the hand-off state before the result is out.
// Throughput: one item at a time; a ray holds the block until its result is handed
//   off, bound by the single map read per cycle and the bit-serial root unit.
// Reset: control and registers return to defaults; the map is undefined.
// ----------------------------------------------------------------------------
// Keeps a one-bit occupancy grid and walks rays over it with Bresenham
// stepping, reporting hit distance in mm, maximum range or nothing hit.
// ----------------------------------------------------------------------------
module ray_cast_grid_distance_unit #(
	parameter int MAP_W = 256,
	parameter int MAP_H = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [rcgd_pkg::CELL_W-1:0]         cell_x,
	input  logic [rcgd_pkg::CELL_W-1:0]         cell_y,
	input  logic                                cell_free,
	input  logic [rcgd_pkg::CELL_W-1:0]         start_x,
	input  logic [rcgd_pkg::CELL_W-1:0]         start_y,
	input  logic signed [rcgd_pkg::OFS_W-1:0]   ray_dx,
	input  logic signed [rcgd_pkg::OFS_W-1:0]   ray_dy,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rcgd_pkg::DIST_W-1:0]         distance_mm,
	output rcgd_pkg::outcome_t                  outcome,
	// register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcgd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcgd_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import rcgd_pkg::*;

	localparam int DEPTH = MAP_W * MAP_H;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_C,
		ST_MUL_S,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t state_q;

	// registers
	logic [CELL_W-1:0] cell_size_q;
	logic [DIST_W-1:0] max_range_q;

	// walk state
	logic signed [COORD_W-1:0] pos_x_q, pos_y_q;
	logic [CELL_W-1:0]         org_x_q, org_y_q;
	logic                      neg_x_q, neg_y_q, x_major_q;
	logic [MAG_W-1:0]          major_q, minor_q, err_q, cnt_q;
	logic                      rd_pend_q;

	// distance datapath
	logic [MAG_W-1:0]  ex_abs_q, ey_abs_q;
	logic [D2_W-1:0]   d2_q;
	logic [CSQ_W-1:0]  csq_q;
	logic [RAD_W-1:0]  radicand_q;

	// result staging and output register
	logic [DIST_W-1:0] res_dist_q;
	outcome_t          res_outcome_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] distance_q;
	outcome_t          outcome_q;

	// map memory
	logic          grid_mem_q [DEPTH];
	logic          grid_rd_s1;
	logic          rd_en, wr_en;
	logic [31:0]   rd_addr_full, wr_addr_full;

	logic in_xfer;
	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// offset magnitudes at request time
	logic [MAG_W-1:0] dx_mag, dy_mag;
	assign dx_mag = ray_dx[OFS_W-1] ? MAG_W'(~ray_dx + 1'b1) : MAG_W'(ray_dx);
	assign dy_mag = ray_dy[OFS_W-1] ? MAG_W'(~ray_dy + 1'b1) : MAG_W'(ray_dy);

	// Bresenham step
	logic [MAG_W:0]            err_sum;
	logic                      carry;
	logic [MAG_W-1:0]          err_nxt;
	logic                      mv_x, mv_y;
	logic signed [COORD_W-1:0] nx, ny;
	logic                      off_map;

	always_comb begin
		err_sum = {1'b0, err_q} + {1'b0, minor_q};
		carry   = (err_sum >= {1'b0, major_q});
		err_nxt = carry ? MAG_W'(err_sum - {1'b0, major_q}) : MAG_W'(err_sum);
		mv_x    = x_major_q || carry;
		mv_y    = !x_major_q || carry;
		nx = pos_x_q;
		ny = pos_y_q;
		if (mv_x) begin
			nx = neg_x_q ? pos_x_q - 1'b1 : pos_x_q + 1'b1;
		end
		if (mv_y) begin
			ny = neg_y_q ? pos_y_q - 1'b1 : pos_y_q + 1'b1;
		end
		off_map = nx[COORD_W-1] || ny[COORD_W-1]
			|| (32'(nx[COORD_W-2:0]) >= 32'(MAP_W))
			|| (32'(ny[COORD_W-2:0]) >= 32'(MAP_H));
	end

	// memory addressing
	assign rd_addr_full = 32'(ny[COORD_W-2:0]) * 32'(MAP_W) + 32'(nx[COORD_W-2:0]);
	assign wr_addr_full = 32'(cell_y) * 32'(MAP_W) + 32'(cell_x);
	assign wr_en = in_xfer && (req_type == REQ_WRITE)
		&& (32'(cell_x) < 32'(MAP_W)) && (32'(cell_y) < 32'(MAP_H));
	assign rd_en = (state_q == ST_WALK) && !(rd_pend_q && grid_rd_s1)
		&& (cnt_q != '0) && !off_map;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem_q[wr_addr_full[AW-1:0]] <= !cell_free;
		end
		if (rd_en) begin
			grid_rd_s1 <= grid_mem_q[rd_addr_full[AW-1:0]];
		end
	end

	// hit offset from the start cell
	logic signed [COORD_W-1:0] ex, ey;
	assign ex = pos_x_q - $signed({2'b00, org_x_q});
	assign ey = pos_y_q - $signed({2'b00, org_y_q});

	// shared multiplier
	logic [D2_W-1:0]  mul_a;
	logic [CSQ_W-1:0] mul_b;
	logic [RAD_W-1:0] prod;

	always_comb begin
		case (state_q)
			ST_MUL_X: begin
				mul_a = D2_W'(ex_abs_q);
				mul_b = CSQ_W'(ex_abs_q);
			end
			ST_MUL_Y: begin
				mul_a = D2_W'(ey_abs_q);
				mul_b = CSQ_W'(ey_abs_q);
			end
			ST_MUL_C: begin
				mul_a = D2_W'(cell_size_q);
				mul_b = CSQ_W'(cell_size_q);
			end
			default: begin
				mul_a = d2_q;
				mul_b = csq_q;
			end
		endcase
		prod = RAD_W'(mul_a) * RAD_W'(mul_b);
	end

	// square root unit
	logic              root_start, root_busy, root_done;
	logic [ROOT_W-1:0] root;
	assign root_start = (state_q == ST_ROOT_GO);

	rcgd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand_q),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cell_size_q   <= CELL_SIZE_RST;
			max_range_q   <= MAX_RANGE_RST;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			org_x_q       <= '0;
			org_y_q       <= '0;
			neg_x_q       <= 1'b0;
			neg_y_q       <= 1'b0;
			x_major_q     <= 1'b0;
			major_q       <= '0;
			minor_q       <= '0;
			err_q         <= '0;
			cnt_q         <= '0;
			rd_pend_q     <= 1'b0;
			ex_abs_q      <= '0;
			ey_abs_q      <= '0;
			d2_q          <= '0;
			csq_q         <= '0;
			radicand_q    <= '0;
			res_dist_q    <= '0;
			res_outcome_q <= OUTCOME_NONE;
			out_valid_q   <= 1'b0;
			distance_q    <= '0;
			outcome_q     <= OUTCOME_NONE;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CELL_SIZE: cell_size_q <= cfg_data[CELL_W-1:0];
					CFG_MAX_RANGE: max_range_q <= cfg_data[DIST_W-1:0];
					default: ;
				endcase
			end

			// result leaves on transfer, unless the hand-off refills it
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (req_type == REQ_RAY)) begin
						pos_x_q   <= $signed({2'b00, start_x});
						pos_y_q   <= $signed({2'b00, start_y});
						org_x_q   <= start_x;
						org_y_q   <= start_y;
						neg_x_q   <= ray_dx[OFS_W-1];
						neg_y_q   <= ray_dy[OFS_W-1];
						x_major_q <= (dx_mag >= dy_mag);
						major_q   <= (dx_mag >= dy_mag) ? dx_mag : dy_mag;
						minor_q   <= (dx_mag >= dy_mag) ? dy_mag : dx_mag;
						cnt_q     <= (dx_mag >= dy_mag) ? dx_mag : dy_mag;
						err_q     <= '0;
						rd_pend_q <= 1'b0;
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					// earlier cell checked before the next step's bounds
					if (rd_pend_q && grid_rd_s1) begin
						ex_abs_q  <= ex[COORD_W-1] ? MAG_W'(-ex) : MAG_W'(ex);
						ey_abs_q  <= ey[COORD_W-1] ? MAG_W'(-ey) : MAG_W'(ey);
						rd_pend_q <= 1'b0;
						state_q   <= ST_MUL_X;
					end else if (cnt_q == '0) begin
						res_dist_q    <= '0;
						res_outcome_q <= OUTCOME_NONE;
						rd_pend_q     <= 1'b0;
						state_q       <= ST_DONE;
					end else if (off_map) begin
						res_dist_q    <= max_range_q;
						res_outcome_q <= OUTCOME_LEFT;
						rd_pend_q     <= 1'b0;
						state_q       <= ST_DONE;
					end else begin
						pos_x_q   <= nx;
						pos_y_q   <= ny;
						err_q     <= err_nxt;
						cnt_q     <= cnt_q - 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				ST_MUL_X: begin
					d2_q    <= prod[D2_W-1:0];
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					d2_q    <= d2_q + prod[D2_W-1:0];
					state_q <= ST_MUL_C;
				end
				ST_MUL_C: begin
					csq_q   <= prod[CSQ_W-1:0];
					state_q <= ST_MUL_S;
				end
				ST_MUL_S: begin
					radicand_q <= prod;
					state_q    <= ST_ROOT_GO;
				end
				ST_ROOT_GO: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						res_dist_q    <= DIST_W'(root);
						res_outcome_q <= OUTCOME_HIT;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						distance_q  <= res_dist_q;
						outcome_q   <= res_outcome_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign distance_mm = distance_q;
	assign outcome     = outcome_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the hand-off state");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> cnt_q <= major_q)
		else $error("walk count exceeds major length");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && major_q != '0) |-> err_q < major_q)
		else $error("Bresenham error term out of range");

	a_root_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT_GO) |-> !root_busy)
		else $error("root unit started while busy");

endmodule

// File: rtl/rcgd_isqrt.sv
// ----------------------------------------------------------------------------
// rcgd_isqrt
// Integer square root, digit by digit: one result bit per cycle from the top
// even bit position down. Root is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module rcgd_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rcgd_pkg::RAD_W-1:0] radicand,
	output logic                       busy,
	output logic                       done,
	output logic [rcgd_pkg::ROOT_W-1:0] root
);
	import rcgd_pkg::*;

	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;
	logic             fits;

	// one trial subtraction per cycle
	assign trial = res_q + bit_q;
	assign fits  = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				rem_q  <= radicand;
				res_q  <= '0;
				bit_q  <= {2'b01, {(RAD_W-2){1'b0}}};
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				// last digit
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bit_q))
		else $error("root unit digit mask has more than one bit set");

	a_busy_bit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bit_q != '0)
		else $error("root unit busy with empty digit mask");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("root unit done while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("root unit did not start");

endmodule
